// ===== sv/lcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lcp_pkg
// Types and constants shared by the LFU cache policy unit and its cells.
// ----------------------------------------------------------------------------
package lcp_pkg;

    localparam int LCP_KEY_W  = 32;
    localparam int LCP_DATA_W = 32;
    localparam int LCP_CAP_W  = 5;
    localparam int LCP_IDX_W  = 8;   // slot index / rank, up to 256 slots
    localparam int LCP_USED_W = 9;   // occupancy, 0..256
    localparam int LCP_CNT_W  = 32;  // widest use count

    typedef struct packed {
        logic                         action;
        logic signed [LCP_KEY_W-1:0]  key;
        logic signed [LCP_DATA_W-1:0] value;
    } lcp_req_t;

    typedef struct packed {
        logic                         hit;
        logic signed [LCP_DATA_W-1:0] read_value;
        logic                         evicted;
        logic signed [LCP_KEY_W-1:0]  evicted_key;
    } lcp_rsp_t;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [0:0] {
        UPD_HIT    = 1'b0,
        UPD_INSERT = 1'b1
    } lcp_upd_kind_t;

    // partial scan result handed from cell to cell
    typedef struct packed {
        logic                  found;
        logic [LCP_IDX_W-1:0]  match_idx;
        logic [LCP_DATA_W-1:0] match_data;
        logic [LCP_IDX_W-1:0]  match_rank;
        logic [LCP_USED_W-1:0] used;
        logic                  vic_valid;
        logic [LCP_IDX_W-1:0]  vic_idx;
        logic [LCP_CNT_W-1:0]  vic_count;
        logic [LCP_IDX_W-1:0]  vic_rank;
        logic [LCP_KEY_W-1:0]  vic_key;
        logic                  free_valid;
        logic [LCP_IDX_W-1:0]  free_idx;
    } lcp_scan_t;

    // update broadcast to all cells
    typedef struct packed {
        logic                  en;
        lcp_upd_kind_t         kind;
        logic                  wr_data;
        logic [LCP_IDX_W-1:0]  target;
        logic [LCP_IDX_W-1:0]  old_rank;
        logic [LCP_KEY_W-1:0]  key;
        logic [LCP_DATA_W-1:0] data;
    } lcp_upd_t;

endpackage

// ===== sv/lcp_cell.sv =====
// ----------------------------------------------------------------------------
// lcp_cell
// One cache slot: holds key, data, use count and recency rank, folds itself
// into the scan result passed along the chain, and applies updates.
// ----------------------------------------------------------------------------
module lcp_cell #(
    parameter int IDX         = 0,
    parameter int COUNT_WIDTH = 16,
    parameter int RANK_W      = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       scan_en,
    input  logic [lcp_pkg::LCP_KEY_W-1:0] req_key,
    input  lcp_pkg::lcp_scan_t         scan_in,
    output lcp_pkg::lcp_scan_t         scan_out,
    input  lcp_pkg::lcp_upd_t          upd
);
    import lcp_pkg::*;

    logic                   valid_reg;
    logic [LCP_KEY_W-1:0]   key_reg;
    logic [LCP_DATA_W-1:0]  data_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [RANK_W-1:0]      rank_reg;
    lcp_scan_t              scan_reg;
    lcp_scan_t              scan_next;
    logic                   is_target;
    logic                   older_cand;

    assign scan_out  = scan_reg;
    assign is_target = (upd.target == LCP_IDX_W'(IDX));

    always_comb
    begin
        scan_next  = scan_in;
        older_cand = (LCP_CNT_W'(count_reg) == scan_in.vic_count)
                     && (LCP_IDX_W'(rank_reg) > scan_in.vic_rank);
        if (valid_reg)
        begin
            scan_next.used = scan_in.used + LCP_USED_W'(1);
            if (!scan_in.found && key_reg == req_key)
            begin
                scan_next.found      = 1'b1;
                scan_next.match_idx  = LCP_IDX_W'(IDX);
                scan_next.match_data = data_reg;
                scan_next.match_rank = LCP_IDX_W'(rank_reg);
            end
            if (!scan_in.vic_valid || LCP_CNT_W'(count_reg) < scan_in.vic_count || older_cand)
            begin
                scan_next.vic_valid = 1'b1;
                scan_next.vic_idx   = LCP_IDX_W'(IDX);
                scan_next.vic_count = LCP_CNT_W'(count_reg);
                scan_next.vic_rank  = LCP_IDX_W'(rank_reg);
                scan_next.vic_key   = key_reg;
            end
        end
        else if (!scan_in.free_valid)
        begin
            scan_next.free_valid = 1'b1;
            scan_next.free_idx   = LCP_IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_en)
        begin
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (upd.en && is_target && upd.kind == UPD_INSERT)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.en)
        begin
            if (is_target)
            begin
                rank_reg <= '0;
                if (upd.kind == UPD_INSERT)
                begin
                    key_reg   <= upd.key;
                    data_reg  <= upd.data;
                    count_reg <= COUNT_WIDTH'(1);
                end
                else
                begin
                    if (upd.wr_data)
                    begin
                        data_reg <= upd.data;
                    end
                    if (count_reg != '1)
                    begin
                        count_reg <= count_reg + COUNT_WIDTH'(1);
                    end
                end
            end
            else if (valid_reg && LCP_IDX_W'(rank_reg) < upd.old_rank)
            begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

endmodule

// ===== sv/lfu_cache_policy_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_policy_unit
// Fully associative key/value store, LFU replacement with LRU tie-break.
// ----------------------------------------------------------------------------
//  channel | signals                          | meaning
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_req       | get/put request
//  out     | out_valid, out_stall, out_rsp    | hit, value, eviction
//  cfg     | cfg_wr_en, cfg_wr_data           | capacity register
//
//  A request moves through accept, one scan step per cell along the chain,
//  then the update step that writes the result register.
//  Reset clears all slot valid bits and sets capacity to 16.
//  The next request is accepted while a result waits on a stalled output;
//  the update cycle holds until the result register is free.
// ----------------------------------------------------------------------------
module lfu_cache_policy_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  lcp_pkg::lcp_req_t             in_req,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lcp_pkg::lcp_rsp_t             out_rsp,
    input  logic                          cfg_wr_en,
    input  logic [lcp_pkg::LCP_CAP_W-1:0] cfg_wr_data
);
    import lcp_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [IW-1:0]         step_reg;
    logic [LCP_CAP_W-1:0]  capacity_reg;
    lcp_req_t              req_reg;
    logic                  out_valid_reg;
    lcp_rsp_t              rsp_reg, rsp_next;
    lcp_upd_t              upd;
    lcp_scan_t             chain [MAX_ENTRIES+1];
    lcp_scan_t             fin;
    logic                  accept;
    logic                  advance;
    logic [LCP_USED_W-1:0] cap_ext, cap_eff;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_reg;
    assign advance   = (state_reg == ST_UPDATE) && !(out_valid_reg && out_stall);
    assign fin       = chain[MAX_ENTRIES];
    assign chain[0]  = '0;

    assign cap_ext = LCP_USED_W'(capacity_reg);
    assign cap_eff = (cap_ext > LCP_USED_W'(MAX_ENTRIES)) ? LCP_USED_W'(MAX_ENTRIES) : cap_ext;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lcp_cell #(
            .IDX         (i),
            .COUNT_WIDTH (COUNT_WIDTH),
            .RANK_W      (IW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_en  ((state_reg == ST_SCAN) && (step_reg == IW'(i))),
            .req_key  (req_reg.key),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1]),
            .upd      (upd)
        );
    end

    always_comb
    begin
        upd          = '0;
        upd.kind     = UPD_HIT;
        upd.key      = req_reg.key;
        upd.data     = req_reg.value;
        rsp_next     = '0;
        rsp_next.hit = fin.found;
        if (req_reg.action == ACT_GET)
        begin
            rsp_next.read_value = fin.found ? $signed(fin.match_data) : -32'sd1;
            upd.en       = fin.found;
            upd.target   = fin.match_idx;
            upd.old_rank = fin.match_rank;
        end
        else if (fin.found)
        begin
            upd.en       = 1'b1;
            upd.wr_data  = 1'b1;
            upd.target   = fin.match_idx;
            upd.old_rank = fin.match_rank;
        end
        else if (cap_eff != '0)
        begin
            upd.kind = UPD_INSERT;
            if (fin.used >= cap_eff && fin.vic_valid)
            begin
                upd.en               = 1'b1;
                upd.target           = fin.vic_idx;
                upd.old_rank         = fin.vic_rank;
                rsp_next.evicted     = 1'b1;
                rsp_next.evicted_key = $signed(fin.vic_key);
            end
            else if (fin.free_valid)
            begin
                upd.en       = 1'b1;
                upd.target   = fin.free_idx;
                upd.old_rank = LCP_IDX_W'(fin.used);
            end
        end
        upd.en = upd.en && advance;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == IW'(MAX_ENTRIES - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            capacity_reg  <= LCP_CAP_W'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN)
            begin
                step_reg <= step_reg + IW'(1);
            end
            else
            begin
                step_reg <= '0;
            end
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (step_reg == '0))
        else $error("accepted request did not start a scan");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_rsp.hit && out_rsp.evicted))
        else $error("response flags both hit and eviction");

    a_update_writes_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid && (state_reg == ST_IDLE))
        else $error("update cycle did not post a response");

endmodule
